/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/petd_pkg.sv */
// ----------------------------------------------------------------------------
// petd_pkg
// Widths, sequencer states and width helpers for the prime enumerator.
// ----------------------------------------------------------------------------
package petd_pkg;

   localparam int VALUE_WIDTH = 16;                 // arithmetic width, 4..32
   localparam int FIELD_W     = 16;                 // width of limit and result fields
   localparam int CNT_W       = $clog2(VALUE_WIDTH); // divider bit counter

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_CMP,
      ST_DIV,
      ST_REM,
      ST_OUT
   } petd_state_type;

   // Limit register field masked to the arithmetic width.
   function automatic logic [VALUE_WIDTH-1:0] limit_of(input logic [FIELD_W-1:0] d);
      logic [VALUE_WIDTH+FIELD_W-1:0] wide;
      wide = {{VALUE_WIDTH{1'b0}}, d};
      return wide[VALUE_WIDTH-1:0];
   endfunction

   // Arithmetic value masked to the result field width.
   function automatic logic [FIELD_W-1:0] field_of(input logic [VALUE_WIDTH-1:0] v);
      logic [VALUE_WIDTH+FIELD_W-1:0] wide;
      wide = {{FIELD_W{1'b0}}, v};
      return wide[FIELD_W-1:0];
   endfunction

endpackage

/* hdl/prime_enumerator_trial_division_unit.sv */
// ----------------------------------------------------------------------------
// prime_enumerator_trial_division_unit
// Gives the next prime up to a programmable limit on each request.
// ----------------------------------------------------------------------------
// Each request returns the next prime above the last one returned, up to and
// including csr_upper_limit; with req_restart high the search begins again
// from 2. When no prime is left at or below the limit the response carries
// rsp_exhausted = 1 and rsp_prime_value = 0, and the last prime is kept, so a
// raised limit continues from where the enumeration stopped. A restart that
// finds nothing still forgets the last prime. Primality is
// tested by trial division with divisors d = 2, 3, ... while d*d <= n, each
// remainder coming from one restoring divider that retires one bit a cycle.
// Per candidate the sequencer first checks the range, then for each trial
// divisor compares the square, runs the divider and tests the remainder; the
// candidate that proves prime ends on one more square compare, while a
// composite stops at its first factor. The block is busy (req_ready low)
// from acceptance until the response is loaded into the output register; a
// pending response waits there while the next request is accepted.
// csr_ready is always high: write the limit only while idle.
// ----------------------------------------------------------------------------
module prime_enumerator_trial_division_unit
   import petd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_restart,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIELD_W-1:0] rsp_prime_value,
   output logic               rsp_exhausted,
   // limit register write
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [FIELD_W-1:0] csr_upper_limit
);

   petd_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] limit_ff,  limit_in;   // masked upper limit
   logic [VALUE_WIDTH-1:0] last_ff,   last_in;    // last prime returned
   logic [VALUE_WIDTH:0]   cand_ff,   cand_in;    // candidate, may reach limit + 1
   logic [VALUE_WIDTH-1:0] div_ff,    div_in;     // trial divisor
   logic [VALUE_WIDTH+1:0] sq_ff,     sq_in;      // div_ff squared, kept incrementally
   logic [VALUE_WIDTH:0]   rem_ff,    rem_in;     // partial remainder
   logic [CNT_W-1:0]       cnt_ff,    cnt_in;     // dividend bit under way
   logic                   found_ff,  found_in;   // prime found, else exhausted

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                   rsp_exh_ff,   rsp_exh_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   over_limit;
   logic                   sq_above;
   logic                   rem_zero;
   logic [VALUE_WIDTH-1:0] cand_low;
   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign over_limit = cand_ff > {1'b0, limit_ff};
   assign sq_above   = sq_ff > {1'b0, cand_ff};
   assign rem_zero   = (rem_ff == '0);

   // Shared restoring divider step: shift in the next dividend bit, subtract
   // the divisor when it fits.
   assign cand_low = cand_ff[VALUE_WIDTH-1:0];
   assign shifted  = {rem_ff[VALUE_WIDTH-1:0], cand_low[cnt_ff]};
   assign diff     = shifted - {1'b0, div_ff};
   assign fits     = shifted >= {1'b0, div_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_TEST;
         end
         ST_TEST: begin
            state_in = over_limit ? ST_OUT : ST_CMP;
         end
         ST_CMP: begin
            state_in = sq_above ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) state_in = ST_REM;
         end
         ST_REM: begin
            state_in = rem_zero ? ST_TEST : ST_CMP;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and response register
   always_comb begin
      limit_in     = limit_ff;
      last_in      = last_ff;
      cand_in      = cand_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_exh_in   = rsp_exh_ff;

      if (csr_valid && csr_ready) limit_in = limit_of(csr_upper_limit);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // restart forgets the last prime and searches from 2 again
               if (req_restart) last_in = VALUE_WIDTH'(1);
               cand_in = req_restart ? (VALUE_WIDTH+1)'(2)
                                     : {1'b0, last_ff} + (VALUE_WIDTH+1)'(1);
            end
         end
         ST_TEST: begin
            found_in = 1'b0;
            div_in   = VALUE_WIDTH'(2);
            sq_in    = (VALUE_WIDTH+2)'(4);
         end
         ST_CMP: begin
            if (sq_above) begin
               found_in = 1'b1;
            end else begin
               rem_in = '0;
               cnt_in = CNT_W'(VALUE_WIDTH - 1);
            end
         end
         ST_DIV: begin
            rem_in = fits ? diff : shifted;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_REM: begin
            if (rem_zero) begin
               cand_in = cand_ff + (VALUE_WIDTH+1)'(1);
            end else begin
               div_in = div_ff + VALUE_WIDTH'(1);
               sq_in  = sq_ff + {1'b0, div_ff, 1'b1};   // (d+1)^2 = d^2 + 2d + 1
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  last_in      = cand_low;
                  rsp_value_in = field_of(cand_low);
                  rsp_exh_in   = 1'b0;
               end else begin
                  rsp_value_in = '0;
                  rsp_exh_in   = 1'b1;
               end
            end
         end
         default: begin
            found_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= '0;
         last_ff      <= VALUE_WIDTH'(1);
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         last_ff      <= last_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_exhausted   = rsp_exh_ff;

endmodule

/* hdl/petd_checker.sv */
// ----------------------------------------------------------------------------
// petd_checker
// Port-level checks on the prime enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module petd_checker
   import petd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [FIELD_W-1:0] rsp_prime_value,
   input logic               rsp_exhausted
);

   // response held until taken
   `CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // busy straight after an accepted request
   `CHK_NEXT(a_busy, req_valid && req_ready, !req_ready, "ready straight after a request")

   `CHK_IMPLY(a_exh_zero, rsp_valid && rsp_exhausted, rsp_prime_value == '0,
              "exhausted response with nonzero value")

   // a prime is never below 2
   `CHK_IMPLY(a_prime_min, rsp_valid && !rsp_exhausted, rsp_prime_value >= FIELD_W'(2),
              "prime response below 2")

endmodule

bind prime_enumerator_trial_division_unit petd_checker u_petd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_prime_value (rsp_prime_value),
   .rsp_exhausted   (rsp_exhausted)
);

/* tb/prime_enumerator_trial_division_unit_tb.sv */
// ----------------------------------------------------------------------------
// prime_enumerator_trial_division_unit_tb
// Self-checking bench for the trial-division prime enumerator: a directed
// table of corner requests, then random phases of limit writes and request
// bursts. Each response is checked against a typed-in value or the in-bench prime predictor.
// ----------------------------------------------------------------------------
module prime_enumerator_trial_division_unit_tb;
   import petd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int RANDOM_ITEMS  = 800;
   localparam int LONG_HOLD     = 2000;   // receiver hold-off during the pressure phase
   localparam int PRESSURE_PH   = 4;      // random phase that carries the hold-off
   localparam int SETTLE_CYCLES = 4;      // quiet cycles before a limit write
   localparam int END_CYCLES    = 100;    // drain time after the last response
   localparam int STALL_LIMIT   = 100000; // watchdog: cycles with no handshake at all
   localparam int N_DIRECTED    = 24;

   localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;

   // One response as the block should present it.
   typedef struct packed {
      logic [FIELD_W-1:0] prime_value;
      logic               exhausted;
   } prime_rsp_type;

   // Directed table: either a limit write or a request.
   typedef enum bit {ROW_LIMIT, ROW_REQUEST} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [FIELD_W-1:0] limit;
      bit                 restart;
      bit                 fixed;   // use the typed-in response instead of the predictor
      prime_rsp_type      rsp;
   } directed_row_type;

   // DUT pins - all inputs known from time zero
   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic               req_restart     = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [FIELD_W-1:0] rsp_prime_value;
   logic               rsp_exhausted;
   logic               csr_valid       = 1'b0;
   logic               csr_ready;
   logic [FIELD_W-1:0] csr_upper_limit = '0;

   // Predictor state: its own copy of the limit register and the last prime.
   logic [FIELD_W-1:0]   limit_q      = '0;
   logic [VALUE_WIDTH:0] last_prime_q = (VALUE_WIDTH+1)'(1);

   prime_rsp_type pending_primes[$];   // responses still owed by the block
   int         mismatch_count = 0;
   int         requests_sent  = 0;
   int         burst_left     = 0;
   int         idle_cycles    = 0;
   bit         long_hold_due  = 1'b0;

   // Corner table. Typed-in responses only where obvious: limit below 2,
   // exhaustion, restart from 2, continuation after the limit is raised.
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b1, '{16'd0, 1'b1}},  // straight after reset
      '{ROW_REQUEST, 16'd0,     1'b1, 1'b1, '{16'd0, 1'b1}},  // restart, limit 0
      '{ROW_LIMIT,   16'd1,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b1, '{16'd0, 1'b1}},  // limit 1: never prime
      '{ROW_LIMIT,   16'd2,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b1, '{16'd2, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b1, '{16'd0, 1'b1}},  // exhausted, 2 is kept
      '{ROW_LIMIT,   16'd3,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b1, '{16'd3, 1'b0}},  // raised limit carries on
      '{ROW_LIMIT,   16'd30,    1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_LIMIT,   16'd12,    1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b1, '{16'd0, 1'b1}},  // limit now under last prime
      '{ROW_REQUEST, 16'd0,     1'b1, 1'b1, '{16'd2, 1'b0}},  // restart
      '{ROW_LIMIT,   16'hFFFF,  1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b1, 1'b1, '{16'd2, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_LIMIT,   16'd0,     1'b0, 1'b0, '{16'd0, 1'b0}},
      '{ROW_REQUEST, 16'd0,     1'b1, 1'b1, '{16'd0, 1'b1}}   // restart into limit 0
   };

   prime_enumerator_trial_division_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_value (rsp_prime_value),
      .rsp_exhausted   (rsp_exhausted),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_upper_limit (csr_upper_limit)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Trial division up to the square root; same verdict as going to n/2.
   function automatic bit is_prime_num(input longint unsigned n);
      longint unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Next prime above the last one, or exhaustion. The last prime only moves
   // when a prime is handed out, so a later raise of the limit carries on.
   function automatic prime_rsp_type next_prime(input bit restart);
      longint unsigned lim;
      longint unsigned c;
      prime_rsp_type   res;
      lim = longint'(limit_q) & VALUE_MASK;
      res = '{prime_value: '0, exhausted: 1'b1};
      if (restart) last_prime_q = (VALUE_WIDTH+1)'(1);
      for (c = longint'(last_prime_q) + 1; c <= lim; c++) begin
         if (is_prime_num(c)) begin
            last_prime_q    = c[VALUE_WIDTH:0];
            res.prime_value = c[FIELD_W-1:0];
            res.exhausted   = 1'b0;
            return res;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------

   // Offer one request and hold it until taken; the expectation is booked on
   // the accepting edge.
   task automatic send_request(input bit restart, input bit fixed,
                               input prime_rsp_type typed);
      prime_rsp_type pred;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = next_prime(restart);
      pending_primes.push_back(fixed ? typed : pred);
      requests_sent++;
   endtask

   // Burst pacing: random burst lengths, random gaps, some gapless bursts.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         repeat (gap) begin
            @(negedge clock);
            req_valid   <= 1'b0;
            req_restart <= 1'($urandom_range(0, 1));   // noise on an idle bus
         end
      end
      burst_left--;
   endtask

   // Limit write, only with the block idle: stop offering, wait for every
   // owed response, let it settle, then write.
   task automatic write_limit(input logic [FIELD_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_primes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_upper_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_q = value;
      @(negedge clock);
      csr_valid       <= 1'b0;
      csr_upper_limit <= FIELD_W'($urandom);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: own stall pattern, plus one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : receiver
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_due) begin
            // Hold the response back while the sender keeps offering, so the
            // output register and the search both fill and req_ready drops.
            long_hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (mode_left % 16) < 4;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response checker: field by field against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      prime_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_primes.size() == 0) begin
            $display("%0t: response with nothing outstanding, prime_value %0d exhausted %0d",
                     $time, rsp_prime_value, rsp_exhausted);
            mismatch_count++;
         end else begin
            want = pending_primes.pop_front();
            if (rsp_prime_value !== want.prime_value) begin
               $display("%0t: prime_value expected %0d actual %0d",
                        $time, want.prime_value, rsp_prime_value);
               mismatch_count++;
            end
            if (rsp_exhausted !== want.exhausted) begin
               $display("%0t: exhausted expected %0d actual %0d",
                        $time, want.exhausted, rsp_exhausted);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a run of cycles with no handshake on any channel is a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int                 phase;
      int                 n_items;
      int                 pick;
      logic [FIELD_W-1:0] lim;
      phase = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners, back to back
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_LIMIT) begin
            write_limit(directed_rows[i].limit);
         end else begin
            send_request(directed_rows[i].restart, directed_rows[i].fixed,
                         directed_rows[i].rsp);
         end
      end

      // Random phases: one limit per phase, then a stretch of requests that
      // mostly continue the enumeration, with the odd restart thrown in.
      // Small limits dominate so that exhaustion and raised-limit carry-on
      // come up often; full-range and extreme limits appear now and then.
      while (requests_sent < N_DIRECTED + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: lim = FIELD_W'($urandom_range(0, 2));
            1: lim = 16'hFFFF;
            2: lim = FIELD_W'($urandom_range(0, 16'hFFFF));
            default: lim = FIELD_W'($urandom_range(3, 400));
         endcase
         write_limit(lim);
         n_items = $urandom_range(8, 50);
         if (phase == PRESSURE_PH) begin
            n_items       = 40;
            long_hold_due = 1'b1;
         end
         repeat (n_items) begin
            pace_sender();
            send_request($urandom_range(0, 9) == 0, 1'b0, '0);
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_primes.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_primes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* prime_enumerator_trial_division_unit.f */
+incdir+hdl
hdl/petd_pkg.sv
hdl/prime_enumerator_trial_division_unit.sv
hdl/petd_checker.sv
tb/prime_enumerator_trial_division_unit_tb.sv
